// ===== hw/rtl/pcgj_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Jacobi PCG init stream.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package pcgj_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned FRAC_W = 16;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [LEN_W-1:0]         len_t;

  // Multiplier operand select codes
  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_MZ = 2'd0;  // m_inv * r
  localparam mul_sel_t MUL_RZ = 2'd1;  // r * z
  localparam mul_sel_t MUL_RR = 2'd2;  // r * r

  // Controller to datapath commands
  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_z;
    logic     acc_rz;
    logic     acc_rr;
    logic     emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } status_t;

  // Clamp a wide signed value to signed 32 bits
  function automatic q16_t sat32(input logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] hi;
    logic signed [ACC_W:0] lo;
    hi = (ACC_W+1)'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
    lo = -hi - (ACC_W+1)'(1);
    if (v > hi) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return v[DATA_W-1:0];
  endfunction

  // Add a term to an accumulator, clamped to signed 64 bits
  function automatic acc_t sat_add64(input acc_t a, input acc_t t);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {t[ACC_W-1], t};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pcgj_in_if.sv =====
// Input request channel: one vector element (b, ax, m_inv) per request.
// Depends on pcgj_pkg for the field types.
`default_nettype none

interface pcgj_in_if;
  logic          valid;
  logic          ready;
  pcgj_pkg::q16_t rhs_value;
  pcgj_pkg::q16_t product_value;
  pcgj_pkg::q16_t inv_diag_value;

  modport source (output valid, output rhs_value, output product_value,
                  output inv_diag_value, input ready);
  modport sink   (input valid, input rhs_value, input product_value,
                  input inv_diag_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pcgj_out_if.sv =====
// Result request channel: r, z, last mark and the running dot products.
// Depends on pcgj_pkg for the field types.
`default_nettype none

interface pcgj_out_if;
  logic                      valid;
  logic                      ready;
  pcgj_pkg::q16_t            residual;
  pcgj_pkg::q16_t            precond_residual;
  logic                      last;
  pcgj_pkg::acc_t            rz_sum;
  logic [pcgj_pkg::ACC_W-2:0] rr_sum;

  modport source (output valid, output residual, output precond_residual,
                  output last, output rz_sum, output rr_sum, input ready);
  modport sink   (input valid, input residual, input precond_residual,
                  input last, input rz_sum, input rr_sum, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pcgj_cfg_if.sv =====
// Configuration write channel carrying the vector length register.
// Depends on pcgj_pkg for the length type.
`default_nettype none

interface pcgj_cfg_if;
  logic           valid;
  logic           ready;
  pcgj_pkg::len_t vector_length;

  modport source (output valid, output vector_length, input ready);
  modport sink   (input valid, input vector_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pcg_jacobi_init_stream.sv =====
// Top level of the Jacobi PCG init stream: controller plus datapath.
// Depends on pcgj_pkg, pcgj_in_if, pcgj_out_if, pcgj_cfg_if, pcgj_ctrl, pcgj_dp.
//
//   channel   dir  payload                                         handshake
//   in_req    in   rhs_value, product_value, inv_diag_value        valid/ready
//   out_rsp   out  residual, precond_residual, last, rz_sum, rr_sum valid/ready
//   cfg_wr    in   vector_length                                   valid/ready
//
// Each request steps from acceptance through MZ, SATZ, MRZ, ACCZ, ACCR and
// EMIT: one 32x32 multiplier is shared in turn for m_inv*r, r*z and r*r, with
// a register after each product. The block takes no new request until the last
// one has entered the output register; the idle state that follows accepts the
// next request while that result may still wait.
// Reset (rst_n low, synchronous) clears the counter and sums and sets the
// length to 1. A stalled out_rsp holds the sequencer in its emit step.
`default_nettype none

module pcg_jacobi_init_stream #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pcgj_in_if.sink    in_req,
  pcgj_out_if.source out_rsp,
  pcgj_cfg_if.sink   cfg_wr
);

  pcgj_pkg::cmd_t    cmd;
  pcgj_pkg::status_t stat;

  // Configuration writes are taken at any time
  assign cfg_wr.ready = 1'b1;

  pcgj_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcgj_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .rhs_value      (in_req.rhs_value),
    .product_value  (in_req.product_value),
    .inv_diag_value (in_req.inv_diag_value),
    .cfg_valid      (cfg_wr.valid),
    .cfg_length     (cfg_wr.vector_length),
    .out_valid      (out_rsp.valid),
    .out_ready      (out_rsp.ready),
    .out_residual   (out_rsp.residual),
    .out_precond    (out_rsp.precond_residual),
    .out_last       (out_rsp.last),
    .out_rz_sum     (out_rsp.rz_sum),
    .out_rr_sum     (out_rsp.rr_sum)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pcgj_ctrl.sv =====
// Sequencer for the PCG init stream: steps one element through the shared multiplier.
// Depends on pcgj_pkg for the command and status structs.
`default_nettype none

module pcgj_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pcgj_pkg::status_t stat,
  output pcgj_pkg::cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MZ   = 3'd1;
  localparam logic [2:0] ST_SATZ = 3'd2;
  localparam logic [2:0] ST_MRZ  = 3'd3;
  localparam logic [2:0] ST_ACCZ = 3'd4;
  localparam logic [2:0] ST_ACCR = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Decode state into datapath commands and next state
  always_comb begin
    cmd       = '0;
    cmd.mul_sel = pcgj_pkg::MUL_MZ;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MZ;
        end
      end
      ST_MZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pcgj_pkg::MUL_MZ;
        state_nxt   = ST_SATZ;
      end
      ST_SATZ: begin
        cmd.ld_z  = 1'b1;
        state_nxt = ST_MRZ;
      end
      ST_MRZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pcgj_pkg::MUL_RZ;
        state_nxt   = ST_ACCZ;
      end
      ST_ACCZ: begin
        cmd.acc_rz  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pcgj_pkg::MUL_RR;
        state_nxt   = ST_ACCR;
      end
      ST_ACCR: begin
        cmd.acc_rr = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pcgj_dp.sv =====
// Datapath for the PCG init stream: residual, shared multiplier, accumulators,
// element counter, length register and output register. Depends on pcgj_pkg.
`default_nettype none

module pcgj_dp #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pcgj_pkg::cmd_t        cmd,
  output pcgj_pkg::status_t          stat,
  input  wire pcgj_pkg::q16_t        rhs_value,
  input  wire pcgj_pkg::q16_t        product_value,
  input  wire pcgj_pkg::q16_t        inv_diag_value,
  input  wire logic                  cfg_valid,
  input  wire pcgj_pkg::len_t        cfg_length,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output pcgj_pkg::q16_t             out_residual,
  output pcgj_pkg::q16_t             out_precond,
  output logic                       out_last,
  output pcgj_pkg::acc_t             out_rz_sum,
  output logic [pcgj_pkg::ACC_W-2:0] out_rr_sum
);

  localparam int unsigned CW = ($clog2(MAX_LENGTH + 1) > 1) ? $clog2(MAX_LENGTH + 1) : 1;
  localparam int unsigned LW = (CW > pcgj_pkg::LEN_W) ? CW + 1 : pcgj_pkg::LEN_W + 1;

  pcgj_pkg::q16_t minv_r;
  pcgj_pkg::q16_t r_r;
  pcgj_pkg::q16_t z_r;
  pcgj_pkg::acc_t prod_r;
  pcgj_pkg::acc_t rz_acc_r;
  pcgj_pkg::acc_t rr_acc_r;
  pcgj_pkg::len_t len_r;
  logic [CW-1:0]  count_r;
  logic           out_valid_r;
  pcgj_pkg::q16_t out_r_r;
  pcgj_pkg::q16_t out_z_r;
  logic           out_last_r;
  pcgj_pkg::acc_t out_rz_r;
  logic [pcgj_pkg::ACC_W-2:0] out_rr_r;

  pcgj_pkg::q16_t mul_a;
  pcgj_pkg::q16_t mul_b;
  pcgj_pkg::acc_t prod_nxt;
  pcgj_pkg::acc_t term;
  logic signed [pcgj_pkg::ACC_W:0] diff;
  logic [LW-1:0]  len_eff;
  logic [LW-1:0]  len_ext;
  logic [LW-1:0]  count_inc;
  logic           is_last;

  // Residual from the incoming request, exact then clamped
  assign diff = (pcgj_pkg::ACC_W+1)'(rhs_value) - (pcgj_pkg::ACC_W+1)'(product_value);

  // Select multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      pcgj_pkg::MUL_MZ: begin
        mul_a = minv_r;
        mul_b = r_r;
      end
      pcgj_pkg::MUL_RZ: begin
        mul_a = r_r;
        mul_b = z_r;
      end
      pcgj_pkg::MUL_RR: begin
        mul_a = r_r;
        mul_b = r_r;
      end
      default: begin
        mul_a = r_r;
        mul_b = r_r;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign term     = prod_r >>> pcgj_pkg::FRAC_W;

  // Effective length: zero acts as one, clamp to the maximum
  assign len_ext = LW'(len_r);
  always_comb begin
    if (len_r == '0) begin
      len_eff = LW'(1);
    end else if (len_ext > LW'(MAX_LENGTH)) begin
      len_eff = LW'(MAX_LENGTH);
    end else begin
      len_eff = len_ext;
    end
  end
  assign count_inc = LW'(count_r) + LW'(1);
  assign is_last   = (count_inc >= len_eff);

  // Operand and intermediate registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      minv_r <= inv_diag_value;
      r_r    <= pcgj_pkg::sat32(diff);
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.ld_z) begin
      z_r <= pcgj_pkg::sat32((pcgj_pkg::ACC_W+1)'(term));
    end
  end

  // Accumulators, element counter and length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rz_acc_r <= '0;
      rr_acc_r <= '0;
      count_r  <= '0;
      len_r    <= pcgj_pkg::LEN_W'(1);
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_length;
      end
      if (cmd.acc_rz) begin
        rz_acc_r <= pcgj_pkg::sat_add64(rz_acc_r, term);
      end
      if (cmd.acc_rr) begin
        rr_acc_r <= pcgj_pkg::sat_add64(rr_acc_r, term);
      end
      if (cmd.emit) begin
        if (is_last) begin
          rz_acc_r <= '0;
          rr_acc_r <= '0;
          count_r  <= '0;
        end else begin
          count_r <= count_inc[CW-1:0];
        end
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r_r    <= r_r;
      out_z_r    <= z_r;
      out_last_r <= is_last;
      out_rz_r   <= rz_acc_r;
      out_rr_r   <= rr_acc_r[pcgj_pkg::ACC_W-2:0];
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_residual  = out_r_r;
  assign out_precond   = out_z_r;
  assign out_last      = out_last_r;
  assign out_rz_sum    = out_rz_r;
  assign out_rr_sum    = out_rr_r;

  // r.r accumulator never goes negative
  a_rr_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !rr_acc_r[pcgj_pkg::ACC_W-1])
    else $error("rr accumulator went negative");

  // a last result clears the vector state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && is_last) |=> (count_r == '0 && rz_acc_r == '0 && rr_acc_r == '0))
    else $error("vector state not cleared after last element");

  // emit only into a free output slot, and it shows next cycle
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (stat.out_free ##1 out_valid_r))
    else $error("result emitted into an occupied output register");

  // counter stays below the maximum length
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(count_r) < LW'(MAX_LENGTH))
    else $error("element counter out of range");

endmodule

`default_nettype wire
